// File: design/deqs_pkg.sv
// Shared types and codes for the bounded deque with search.
package deqs_pkg;

    localparam int unsigned DATA_W = 32;

    // Operation codes carried on i_op
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    // Status codes reported on o_status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_FRONT,
        S_BACK,
        S_CAP
    } t_state;

endpackage

// File: design/double_ended_queue_with_search_core.sv
// Bounded deque of signed 32-bit values with a sequential search over a ring memory.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-------------------------------
//  command  | i_op, i_value                            | transfer when start && !busy
//  result   | o_status, o_found, o_count,              | transfer in the cycle o_strobe
//           | o_front_value, o_back_value              | is high (no back-pressure)
//
// Pushes, pops and undefined ops step through S_EXEC, S_FRONT, S_BACK and S_CAP.
// A search adds S_SRCH after S_EXEC, scanning up to count entries (left early on a hit): the single
// registered read port of the ring memory delivers one entry per cycle.
// busy is high from the cycle after a transfer through the cycle before the strobe.
// Reset clears head and count; ring contents are not cleared and are read only
// where written. The receiver cannot stall; each result is shown for one cycle.
module double_ended_queue_with_search_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_op,
    input  logic signed [deqs_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic [1:0]                        o_status,
    output logic                              o_found,
    output logic [$clog2(DEPTH+1)-1:0]        o_count,
    output logic signed [deqs_pkg::DATA_W-1:0] o_front_value,
    output logic signed [deqs_pkg::DATA_W-1:0] o_back_value
);
    import deqs_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] pos);
        logic [AW:0] diff;
        diff = pos - DEPTH_W;
        return (pos >= DEPTH_W) ? diff[AW-1:0] : pos[AW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic          r_found, n_found;
    logic [1:0]    r_stat, n_stat;
    logic [2:0]    r_op;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_front;
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_mem [DEPTH];

    logic          r_strobe, n_strobe;
    logic [1:0]    r_o_stat;
    logic          r_o_found;
    logic [CW-1:0] r_o_cnt;
    logic signed [DATA_W-1:0] r_o_front, r_o_back;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;
    logic          full, empty, issue, hit;
    logic [AW-1:0] tail_pos, back_pos, srch_pos, head_inc, head_dec;
    logic [CW-1:0] cnt_m1;

    assign full     = (r_cnt == DEPTH_C);
    assign empty    = (r_cnt == '0);
    assign cnt_m1   = r_cnt - 1'b1;
    assign tail_pos = ring_wrap({1'b0, r_head} + (AW + 1)'(r_cnt));
    assign back_pos = ring_wrap({1'b0, r_head} + (AW + 1)'(cnt_m1));
    assign srch_pos = ring_wrap({1'b0, r_head} + (AW + 1)'(r_idx));
    assign head_inc = ring_wrap({1'b0, r_head} + (AW + 1)'(1));
    assign head_dec = (r_head == '0) ? LAST_POS : r_head - 1'b1;
    assign issue    = (r_idx < r_cnt);
    assign hit      = r_pend && (r_rd_data == r_value);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_found   = r_found;
        n_stat    = r_stat;
        n_strobe  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = tail_pos;
        rd_addr   = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_stat  = STAT_OK;
                n_found = 1'b0;
                n_idx   = '0;
                n_state = S_FRONT;
                unique case (r_op)
                    OP_PUSH_BACK: begin
                        if (full) begin
                            n_stat = STAT_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = tail_pos;
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (full) begin
                            n_stat = STAT_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = head_dec;
                            n_head    = head_dec;
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (empty) begin
                            n_stat = STAT_EMPTY;
                        end else begin
                            n_head = head_inc;
                            n_cnt  = cnt_m1;
                        end
                    end
                    OP_POP_BACK: begin
                        if (empty) begin
                            n_stat = STAT_EMPTY;
                        end else begin
                            n_cnt = cnt_m1;
                        end
                    end
                    OP_SEARCH: begin
                        n_state = S_SRCH;
                    end
                    default: begin
                        n_state = S_FRONT;
                    end
                endcase
            end
            S_SRCH: begin
                // issue one read per cycle, compare the entry read last cycle
                rd_addr = srch_pos;
                if (hit) begin
                    n_found = 1'b1;
                    n_state = S_FRONT;
                end else if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                rd_addr = r_head;
                n_state = S_BACK;
            end
            S_BACK: begin
                rd_addr = back_pos;
                n_state = S_CAP;
            end
            S_CAP: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    // payload and sequencer scratch: no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        r_idx   <= n_idx;
        r_found <= n_found;
        r_stat  <= n_stat;
        if (r_state == S_BACK) begin
            r_front <= r_rd_data;
        end
        if (r_state == S_CAP) begin
            r_o_stat  <= r_stat;
            r_o_found <= r_found;
            r_o_cnt   <= r_cnt;
            r_o_front <= empty ? '0 : r_front;
            r_o_back  <= empty ? '0 : r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_o_stat;
    assign o_found       = r_o_found;
    assign o_count       = r_o_cnt;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == STAT_FULL) |-> (o_count == DEPTH_C))
        else $error("full status with room left");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAP && r_found) |-> (r_op == OP_SEARCH && !empty))
        else $error("found flag outside a search of a non-empty queue");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the bounded deque with search: random commands against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import deqs_pkg::*;

    localparam int unsigned DEPTH     = 16;
    localparam int unsigned ITEMS     = 600;
    localparam int unsigned TAIL_WAIT = 40;
    // Unassigned opcodes: the block must leave the queue alone
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]          status;
        logic                found;
        logic [4:0]          count;
        logic signed [31:0]  front;
        logic signed [31:0]  back;
    } t_reply;

    class t_deque_scoreboard;
        logic signed [31:0] ring [DEPTH];
        int unsigned        head;
        int unsigned        held;
        t_reply             pending_replies [$];
        int unsigned        errors;

        function new();
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        // Apply one accepted command to the shadow deque and queue its reply.
        function void note_command(logic [2:0] op, logic signed [31:0] val);
            t_reply r;
            r.status = STAT_OK;
            r.found  = 1'b0;
            case (op)
                OP_PUSH_BACK: begin
                    if (held == DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        ring[(head + held) % DEPTH] = val;
                        held++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (held == DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        held++;
                    end
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) r.status = STAT_EMPTY;
                    else held--;
                end
                OP_SEARCH: begin
                    for (int unsigned k = 0; k < held; k++)
                        if (ring[(head + k) % DEPTH] == val) r.found = 1'b1;
                end
                default: ;
            endcase
            r.count = 5'(held);
            r.front = (held == 0) ? '0 : ring[head];
            r.back  = (held == 0) ? '0 : ring[(head + held - 1) % DEPTH];
            pending_replies.push_back(r);
        endfunction

        // Return a value currently held, or a random one when empty.
        function logic signed [31:0] pick_held();
            if (held == 0) return $urandom;
            return ring[(head + $urandom_range(0, held - 1)) % DEPTH];
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic found, logic [4:0] count,
                                   logic signed [31:0] front, logic signed [31:0] back);
            t_reply want;
            if (pending_replies.size() == 0) begin
                $error("result strobe with no command outstanding");
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            check_field("status", 32'(want.status), 32'(status));
            check_field("found", 32'(want.found), 32'(found));
            check_field("count", 32'(want.count), 32'(count));
            check_field("front_value", want.front, front);
            check_field("back_value", want.back, back);
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [2:0]         i_op    = OP_PUSH_BACK;
    logic signed [31:0] i_value = '0;
    logic               busy;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic               o_found;
    logic [4:0]         o_count;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_back_value;

    t_deque_scoreboard sb = new();
    bit                no_gaps;

    double_ended_queue_with_search_core #(.DEPTH(DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_status, o_found, o_count, o_front_value, o_back_value);
    end

    // Present one command, hold it until the transfer, then idle for a random gap.
    task automatic issue_cmd(input logic [2:0] op, input logic signed [31:0] val);
        int unsigned gap;
        int unsigned roll;
        start   <= 1'b1;
        i_op    <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, val);
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 40) gap = 0;
        else if (roll < 85) gap = $urandom_range(1, 3);
        else if (roll < 97) gap = $urandom_range(4, 15);
        else gap = $urandom_range(30, 80);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            3, 4, 5: return 32'($urandom_range(0, 15)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    // Filling favors pushes so the queue reaches full; draining favors pops.
    function automatic logic [2:0] rand_op(bit filling);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 55 : 20))
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll < (filling ? 70 : 65))
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (roll < 95) return OP_SEARCH;
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    initial begin
        logic [2:0]         op;
        logic signed [31:0] val;
        bit                 filling;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: underflow on both ends, search miss, unassigned opcode
        issue_cmd(OP_POP_FRONT, 32'sd5);
        issue_cmd(OP_POP_BACK, 32'sd5);
        issue_cmd(OP_SEARCH, 32'sd0);
        issue_cmd(OP_SPARE_HI, 32'sd3);
        // Fill from both ends so the head wraps around the ring
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0:       val = VAL_MIN;
                1:       val = VAL_MAX;
                2:       val = -32'sd1;
                3:       val = 32'sd0;
                4:       val = 32'sd1;
                default: val = $urandom;
            endcase
            issue_cmd(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, val);
        end
        // Overflow on both ends, searches on a full queue, unassigned opcode
        issue_cmd(OP_PUSH_BACK, 32'sd7);
        issue_cmd(OP_PUSH_FRONT, 32'sd7);
        issue_cmd(OP_SEARCH, VAL_MIN);
        issue_cmd(OP_SEARCH, 32'sd7);
        issue_cmd(OP_SPARE_LO, VAL_MAX);

        filling = 1'b0;
        for (int n = 0; n < ITEMS; n++) begin
            if (n % 40 == 0) filling = $urandom_range(0, 1);
            no_gaps = (n % 100) < 20;
            op = rand_op(filling);
            if (op == OP_SEARCH && $urandom_range(0, 1)) val = sb.pick_held();
            else val = rand_value();
            issue_cmd(op, val);
        end
        no_gaps = 1'b0;
        start <= 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
design/deqs_pkg.sv
design/double_ended_queue_with_search_core.sv
verif/testbench.sv
